// ===== hdl/frcs_pkg.sv =====
// Shared types and constants for the rectangle fill command stream.
// Holds the port payload structs, the job record that links the front and
// back parts, status codes, header positions and the colour widening helpers.
`timescale 1ns / 1ps
`default_nettype none
package frcs_pkg;

  // Item kinds on the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PULL  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_BYTE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_SWAP     = 2'd1;
  localparam logic [1:0] REG_PIX18    = 2'd2;

  // Display controller commands
  localparam logic [7:0] OP_CASET = 8'h2A;
  localparam logic [7:0] OP_RASET = 8'h2B;
  localparam logic [7:0] OP_RAMWR = 8'h2C;
  localparam logic [7:0] CH_MASK  = 8'hFC;

  // Positions in the eleven byte header; HDR_PIX means pixels are flowing
  localparam logic [3:0] HDR_CASET = 4'd0;
  localparam logic [3:0] HDR_RASET = 4'd5;
  localparam logic [3:0] HDR_RAMWR = 4'd10;
  localparam logic [3:0] HDR_PIX   = 4'd11;

  typedef struct packed {
    logic       cmd;
    logic [9:0] x;
    logic [9:0] y;
    logic [9:0] w;
    logic [9:0] h;
    logic [15:0] color;
    logic       link_error;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] byte_out;
    logic       is_data;
    logic       last_byte;
  } out_item_t;

  // Classified request handed from the front part to the back part
  typedef struct packed {
    logic        is_pull;
    logic        start_ok;   // geometry and link fine; busy is checked later
    logic [9:0]  col_start;
    logic [9:0]  col_end;
    logic [9:0]  row_start;
    logic [9:0]  row_end;
    logic [9:0]  col_last;   // clipped width minus one
    logic [9:0]  row_last;   // clipped height minus one
    logic [23:0] pixel_bytes;
    logic        fmt18;
  } job_t;

  // Channel widening to eight bits, kept to the upper six bits.
  // c*255/31 is 8c plus a term of at most seven, so after the mask only bit
  // two of that term survives; it is set for channel values of 18 and above.
  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, (c >= 5'd18), 2'b00};
  endfunction

  // c*255/63 is 4c plus a term of at most three, which the mask removes.
  function automatic logic [7:0] widen6(input logic [5:0] c);
    return {c, 2'b00};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fill_rect_command_stream.sv =====
// Top level of the rectangle fill command stream for a serial display.
// Depends on frcs_pkg, frcs_front, frcs_back and frcs_fifo.
//
//   channel   direction  handshake        payload
//   in_       request    in_push/in_full  frcs_pkg::in_item_t (start or pull)
//   out_      result     out_empty/out_pop frcs_pkg::out_item_t (one per request)
//   cfg_      write      cfg_we           cfg_index selects, cfg_data carries value
//
// Every request yields exactly one result, and one request is taken each clock
// cycle while neither side stalls. A request is held in the front register,
// then moves into a two-entry job queue; the back part retires one job a
// cycle, while the result queue has room, into a two-entry result queue.
// A result thus goes through the front register, the job queue and the result
// queue to the output ports. The rate is set by the single back part, which
// updates the fill counters once per job. Reset is synchronous and active low;
// it empties both queues, ends any fill and restores the registers to their
// defaults. A stall on the result side fills the result queue, then the job
// queue and the front register, and only then raises in_full.
`timescale 1ns / 1ps
`default_nettype none
module fill_rect_command_stream #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 480
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire frcs_pkg::in_item_t  in_item,
  output logic                     in_full,
  output logic                     out_empty,
  output frcs_pkg::out_item_t      out_item,
  input  wire logic                out_pop,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [1:0]          cfg_data
);
  import frcs_pkg::*;

  // Configuration registers. The pixel format and the window are captured
  // per request in the front part, so changes only affect later starts.
  logic [1:0] rotation_r;
  logic       swap_r;
  logic       pix18_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= 2'd0;
      swap_r     <= 1'b1;
      pix18_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION: rotation_r <= cfg_data;
        REG_SWAP:     swap_r     <= cfg_data[0];
        REG_PIX18:    pix18_r    <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Front part: classifies each request and clips the rectangle.
  logic  front_valid;
  job_t  front_job;
  logic  jq_full, jq_empty, jq_pop;
  job_t  jq_head;

  frcs_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_item        (in_item),
    .in_full        (in_full),
    .rotation       (rotation_r),
    .swap_on_rotate (swap_r),
    .pixel_18bit    (pix18_r),
    .job_valid      (front_valid),
    .job            (front_job),
    .job_full       (jq_full)
  );

  // Job queue between the two parts, so each can stall on its own.
  frcs_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (2)
  ) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_job),
    .pop       (jq_pop),
    .head      (jq_head),
    .full      (jq_full),
    .empty     (jq_empty)
  );

  // Back part: owns the fill state and emits the byte stream.
  logic       rq_full, rq_push;
  out_item_t  back_res;

  frcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!jq_empty),
    .job       (jq_head),
    .job_take  (jq_pop),
    .res_full  (rq_full),
    .res_push  (rq_push),
    .res       (back_res)
  );

  // Result queue; its head is what the consumer sees.
  frcs_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rq_push),
    .push_data (back_res),
    .pop       (out_pop),
    .head      (out_item),
    .full      (rq_full),
    .empty     (out_empty)
  );

endmodule
`default_nettype wire

// ===== hdl/frcs_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
// Generic in width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module frcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not follow a pop");

endmodule
`default_nettype wire

// ===== hdl/frcs_front.sv =====
// Front part: accepts requests, clips the rectangle and prepares pixel bytes.
// Depends on frcs_pkg for the payload and job types and the widening helpers.
`timescale 1ns / 1ps
`default_nettype none
module frcs_front #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 480
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire frcs_pkg::in_item_t in_item,
  output logic                    in_full,
  input  wire logic [1:0]         rotation,
  input  wire logic               swap_on_rotate,
  input  wire logic               pixel_18bit,
  output logic                    job_valid,
  output frcs_pkg::job_t          job,
  input  wire logic               job_full
);
  import frcs_pkg::*;

  localparam logic [9:0] PW = 10'(PANEL_WIDTH);
  localparam logic [9:0] PH = 10'(PANEL_HEIGHT);

  logic        valid_r, valid_nxt;
  job_t        job_r, job_nxt;
  logic        take, swap;
  logic [9:0]  pw, ph;
  logic [10:0] sum_x, sum_y;

  assign in_full   = valid_r && job_full;
  assign take      = in_push && !in_full;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_comb begin
    swap  = rotation[0] && swap_on_rotate;
    pw    = swap ? PH : PW;
    ph    = swap ? PW : PH;
    sum_x = {1'b0, in_item.x} + {1'b0, in_item.w};
    sum_y = {1'b0, in_item.y} + {1'b0, in_item.h};

    job_nxt.is_pull  = (in_item.cmd == CMD_PULL);
    job_nxt.start_ok = !in_item.link_error && (in_item.w != '0) && (in_item.h != '0)
                       && (in_item.x < pw) && (in_item.y < ph);
    job_nxt.col_start = in_item.x;
    job_nxt.row_start = in_item.y;
    job_nxt.col_end   = (sum_x > {1'b0, pw}) ? pw - 1'b1 : sum_x[9:0] - 1'b1;
    job_nxt.row_end   = (sum_y > {1'b0, ph}) ? ph - 1'b1 : sum_y[9:0] - 1'b1;
    job_nxt.col_last  = job_nxt.col_end - in_item.x;
    job_nxt.row_last  = job_nxt.row_end - in_item.y;
    job_nxt.fmt18     = pixel_18bit;
    if (pixel_18bit) begin
      job_nxt.pixel_bytes = {widen5(in_item.color[15:11]), widen6(in_item.color[10:5]),
                             widen5(in_item.color[4:0])};
    end else begin
      job_nxt.pixel_bytes = {in_item.color, 8'h00};
    end

    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (!job_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/frcs_back.sv =====
// Back part: holds the fill state and turns each queued job into one result.
// Depends on frcs_pkg for the job and result types and the header positions.
`timescale 1ns / 1ps
`default_nettype none
module frcs_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_avail,
  input  wire frcs_pkg::job_t  job,
  output logic                 job_take,
  input  wire logic            res_full,
  output logic                 res_push,
  output frcs_pkg::out_item_t  res
);
  import frcs_pkg::*;

  logic        busy_r, busy_nxt;
  logic [3:0]  hdr_r, hdr_nxt;
  logic [9:0]  col_start_r, col_end_r, row_start_r, row_end_r;
  logic [9:0]  col_last_r, row_last_r;
  logic [9:0]  col_cnt_r, col_cnt_nxt, row_cnt_r, row_cnt_nxt;
  logic [1:0]  pix_idx_r, pix_idx_nxt;
  logic [23:0] pix_r;
  logic        fmt18_r;
  logic        load, step, end_pix, fin;

  assign step     = job_avail && !res_full;
  assign job_take = step;
  assign res_push = step;

  always_comb begin
    busy_nxt    = busy_r;
    hdr_nxt     = hdr_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    pix_idx_nxt = pix_idx_r;
    load        = 1'b0;
    fin         = 1'b0;
    end_pix     = fmt18_r ? (pix_idx_r == 2'd2) : (pix_idx_r != 2'd0);
    res         = '{status: ST_IDLE, byte_out: 8'h00, is_data: 1'b0, last_byte: 1'b0};

    if (step) begin
      if (!job.is_pull) begin
        if (busy_r || !job.start_ok) begin
          res.status = ST_REJECT;
        end else begin
          res.status  = ST_ACCEPT;
          load        = 1'b1;
          busy_nxt    = 1'b1;
          hdr_nxt     = HDR_CASET;
          col_cnt_nxt = '0;
          row_cnt_nxt = '0;
          pix_idx_nxt = '0;
        end
      end else if (!busy_r) begin
        res.status = ST_IDLE;
      end else if (hdr_r != HDR_PIX) begin
        res.status  = ST_BYTE;
        res.is_data = 1'b1;
        hdr_nxt     = hdr_r + 1'b1;
        case (hdr_r)
          HDR_CASET:        begin res.byte_out = OP_CASET; res.is_data = 1'b0; end
          HDR_CASET + 4'd1: res.byte_out = {6'd0, col_start_r[9:8]};
          HDR_CASET + 4'd2: res.byte_out = col_start_r[7:0];
          HDR_CASET + 4'd3: res.byte_out = {6'd0, col_end_r[9:8]};
          HDR_CASET + 4'd4: res.byte_out = col_end_r[7:0];
          HDR_RASET:        begin res.byte_out = OP_RASET; res.is_data = 1'b0; end
          HDR_RASET + 4'd1: res.byte_out = {6'd0, row_start_r[9:8]};
          HDR_RASET + 4'd2: res.byte_out = row_start_r[7:0];
          HDR_RASET + 4'd3: res.byte_out = {6'd0, row_end_r[9:8]};
          HDR_RASET + 4'd4: res.byte_out = row_end_r[7:0];
          default:          begin res.byte_out = OP_RAMWR; res.is_data = 1'b0; end
        endcase
      end else begin
        res.status  = ST_BYTE;
        res.is_data = 1'b1;
        case (pix_idx_r)
          2'd0:    res.byte_out = pix_r[23:16];
          2'd1:    res.byte_out = pix_r[15:8];
          default: res.byte_out = pix_r[7:0];
        endcase
        if (end_pix) begin
          pix_idx_nxt = '0;
          if (col_cnt_r == col_last_r && row_cnt_r == row_last_r) begin
            fin           = 1'b1;
            res.last_byte = 1'b1;
            busy_nxt      = 1'b0;
            hdr_nxt       = HDR_CASET;
            col_cnt_nxt   = '0;
            row_cnt_nxt   = '0;
          end else if (col_cnt_r == col_last_r) begin
            col_cnt_nxt = '0;
            row_cnt_nxt = row_cnt_r + 1'b1;
          end else begin
            col_cnt_nxt = col_cnt_r + 1'b1;
          end
        end else begin
          pix_idx_nxt = pix_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      hdr_r     <= HDR_CASET;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      pix_idx_r <= '0;
      fmt18_r   <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      hdr_r     <= hdr_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      pix_idx_r <= pix_idx_nxt;
      if (load) begin
        fmt18_r <= job.fmt18;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col_start_r <= job.col_start;
      col_end_r   <= job.col_end;
      row_start_r <= job.row_start;
      row_end_r   <= job.row_end;
      col_last_r  <= job.col_last;
      row_last_r  <= job.row_last;
      pix_r       <= job.pixel_bytes;
    end
  end

  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r <= HDR_PIX)
    else $error("header position out of range");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> (!busy_r && hdr_r == HDR_CASET))
    else $error("fill did not end after its last byte");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && hdr_r == HDR_CASET && pix_idx_r == 2'd0))
    else $error("accepted start did not arm the header");

  a_pix_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !fmt18_r) |-> (pix_idx_r != 2'd2))
    else $error("third pixel byte in 16-bit mode");

endmodule
`default_nettype wire
